// ===== rtl/core/gda_pkg.sv =====
package gda_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int AddW   = 15;
  localparam int RemW   = 16;
  localparam int CumW   = 9;

  localparam logic [YearW-1:0] YearCycle  = YearW'(400);
  localparam logic [YearW-1:0] YearLast   = YearW'(399);
  localparam logic [YearW-1:0] Century1   = YearW'(100);
  localparam logic [YearW-1:0] Century2   = YearW'(200);
  localparam logic [YearW-1:0] Century3   = YearW'(300);
  localparam logic [MonthW-1:0] MonthJan  = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb  = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec  = MonthW'(12);

  typedef logic [DayW-1:0]   day_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [YearW-1:0]  year_t;
  typedef logic [AddW-1:0]   add_t;
  typedef logic [RemW-1:0]   rem_t;
  typedef logic [CumW-1:0]   cum_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic prefix;
    logic walk_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic walk_done;
  } sts_t;

  function automatic day_t month_len(month_t m, logic leap);
    day_t len;
    case (m)
      4'd2:                      len = leap ? day_t'(29) : day_t'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = day_t'(30);
      default:                   len = day_t'(31);
    endcase
    return len;
  endfunction

  function automatic cum_t days_before(month_t m, logic leap);
    cum_t cum;
    case (m)
      4'd1:    cum = cum_t'(0);
      4'd2:    cum = cum_t'(31);
      4'd3:    cum = cum_t'(59);
      4'd4:    cum = cum_t'(90);
      4'd5:    cum = cum_t'(120);
      4'd6:    cum = cum_t'(151);
      4'd7:    cum = cum_t'(181);
      4'd8:    cum = cum_t'(212);
      4'd9:    cum = cum_t'(243);
      4'd10:   cum = cum_t'(273);
      4'd11:   cum = cum_t'(304);
      4'd12:   cum = cum_t'(334);
      default: cum = cum_t'(0);
    endcase
    if (leap && (m > MonthFeb)) begin
      cum = cum + cum_t'(1);
    end
    return cum;
  endfunction

endpackage

// ===== rtl/core/gda_if.sv =====
interface gda_in_if;
  logic            valid;
  logic            ready;
  gda_pkg::day_t   start_day;
  gda_pkg::month_t start_month;
  gda_pkg::year_t  start_year;
  gda_pkg::add_t   days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, days_to_add,
                output ready);
endinterface

interface gda_out_if;
  logic            valid;
  logic            ready;
  gda_pkg::day_t   end_day;
  gda_pkg::month_t end_month;
  gda_pkg::year_t  end_year;

  modport source (output valid, end_day, end_month, end_year, input ready);
  modport sink (input valid, end_day, end_month, end_year, output ready);
endinterface

// ===== rtl/core/gda_ctrl.sv =====
module gda_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output gda_pkg::cmd_t cmd,
  input  gda_pkg::sts_t sts
);
  import gda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MOD    = 4'b0010,
    S_PREFIX = 4'b0100,
    S_WALK   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_next = S_PREFIX;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_PREFIX: begin
        cmd.prefix = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/gda_dp.sv =====
module gda_dp (
  input  logic            clk,
  input  gda_pkg::day_t   start_day,
  input  gda_pkg::month_t start_month,
  input  gda_pkg::year_t  start_year,
  input  gda_pkg::add_t   days_to_add,
  input  gda_pkg::cmd_t   cmd,
  output gda_pkg::sts_t   sts,
  output gda_pkg::day_t   end_day,
  output gda_pkg::month_t end_month,
  output gda_pkg::year_t  end_year
);
  import gda_pkg::*;

  rem_t   rem;
  month_t month;
  year_t  year;
  year_t  yr_mod;

  day_t   day_in;
  month_t month_in;
  logic   leap;
  day_t   len;

  always_comb begin
    day_in   = (start_day == '0) ? day_t'(1) : start_day;
    month_in = start_month;
    if (start_month == '0) begin
      month_in = MonthJan;
    end else if (start_month > MonthDec) begin
      month_in = MonthDec;
    end
    leap = (yr_mod[1:0] == 2'b00) && (yr_mod != Century1) &&
           (yr_mod != Century2) && (yr_mod != Century3);
    len  = month_len(month, leap);
    sts.mod_done  = (yr_mod < YearCycle);
    sts.walk_done = (rem <= rem_t'(len));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem    <= rem_t'(day_in) + rem_t'(days_to_add);
      month  <= month_in;
      year   <= start_year;
      yr_mod <= start_year;
    end
    if (cmd.mod_step) begin
      yr_mod <= yr_mod - YearCycle;
    end
    if (cmd.prefix) begin
      rem   <= rem + rem_t'(days_before(month, leap));
      month <= MonthJan;
    end
    if (cmd.walk_step) begin
      rem <= rem - rem_t'(len);
      if (month == MonthDec) begin
        month  <= MonthJan;
        year   <= year + year_t'(1);
        yr_mod <= (yr_mod == YearLast) ? '0 : yr_mod + year_t'(1);
      end else begin
        month <= month + month_t'(1);
      end
    end
    if (cmd.out_load) begin
      end_day   <= rem[DayW-1:0];
      end_month <= month;
      end_year  <= year;
    end
  end

endmodule

// ===== rtl/core/gregorian_date_add_days_unit.sv =====
// Channel   Role    Word
// date_in   sink    start_day, start_month, start_year, days_to_add
// date_out  source  end_day, end_month, end_year
//
// One word is worked on at a time: the unit accepts it, reduces the year
// modulo 400 by repeated subtraction, adds the days before the start month,
// walks from January one month at a time, and then loads the output register
// once the previous output word has been taken. The month walk sets the rate.
// rst is synchronous and clears the controller and the output valid flag.
// A held output word does not block the next input word from being taken.
module gregorian_date_add_days_unit (
  input logic   clk,
  input logic   rst,
  gda_in_if.sink  date_in,
  gda_out_if.source date_out
);
  import gda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (date_in.valid),
    .in_ready  (date_in.ready),
    .out_ready (date_out.ready),
    .out_valid (date_out.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  gda_dp u_dp (
    .clk         (clk),
    .start_day   (date_in.start_day),
    .start_month (date_in.start_month),
    .start_year  (date_in.start_year),
    .days_to_add (date_in.days_to_add),
    .cmd         (cmd),
    .sts         (sts),
    .end_day     (date_out.end_day),
    .end_month   (date_out.end_month),
    .end_year    (date_out.end_year)
  );

endmodule

// ===== rtl/core/gda_checker.sv =====
module gda_props (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input gda_pkg::day_t   end_day,
  input gda_pkg::month_t end_month,
  input gda_pkg::year_t  end_year
);
  import gda_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(end_day) && $stable(end_month) &&
    $stable(end_year))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_month >= MonthJan) && (end_month <= MonthDec))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_day != '0) &&
    ((end_month != MonthFeb) || (end_day <= day_t'(29))))
    else $error("day out of range");

endmodule

bind gregorian_date_add_days_unit gda_props u_gda_props (
  .clk       (clk),
  .rst       (rst),
  .out_valid (date_out.valid),
  .out_ready (date_out.ready),
  .end_day   (date_out.end_day),
  .end_month (date_out.end_month),
  .end_year  (date_out.end_year)
);

// ===== tb/sv/gda_checker.sv =====
module gda_checker (
  input  logic        clk,
  input  logic        rst,
  gda_in_if           date_in,
  gda_out_if          date_out,
  output int unsigned fails,
  output int unsigned pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  date_t dates_due [$];

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m == 32'(MonthFeb)) begin
      return is_leap(y) ? 29 : 28;
    end
    return MonthDays[m - 1];
  endfunction

  function automatic date_t add_days(day_t d, month_t m, year_t y, add_t n);
    int unsigned left;
    int unsigned mon;
    int unsigned yr;
    date_t       res;
    mon  = (m == '0) ? 32'(MonthJan) : (m > MonthDec) ? 32'(MonthDec) : 32'(m);
    left = (d == '0) ? 32'd1 : 32'(d);
    yr   = 32'(y);
    for (int unsigned k = 32'(MonthJan); k < mon; k++) begin
      left += month_days(yr, k);
    end
    left += 32'(n);
    mon = 32'(MonthJan);
    while (left > month_days(yr, mon)) begin
      left -= month_days(yr, mon);
      mon++;
      if (mon > 32'(MonthDec)) begin
        mon = 32'(MonthJan);
        yr++;
      end
    end
    res.day   = day_t'(left);
    res.month = month_t'(mon);
    res.year  = year_t'(yr);
    return res;
  endfunction

  always @(posedge clk) begin
    date_t       got;
    date_t       want;
    int unsigned bad;
    bad = 0;
    if (rst) begin
      dates_due.delete();
      fails   <= 0;
      pending <= 0;
    end else begin
      if (date_out.valid && date_out.ready) begin
        got = '{date_out.end_day, date_out.end_month, date_out.end_year};
        if (dates_due.size() == 0) begin
          bad++;
          $display("%0t date_out: unexpected word, expected none, got %0d-%0d-%0d",
                   $time, got.year, got.month, got.day);
        end else begin
          want = dates_due.pop_front();
          if (got.day !== want.day) begin
            bad++;
            $display("%0t end_day: expected %0d, got %0d", $time, want.day, got.day);
          end
          if (got.month !== want.month) begin
            bad++;
            $display("%0t end_month: expected %0d, got %0d", $time, want.month, got.month);
          end
          if (got.year !== want.year) begin
            bad++;
            $display("%0t end_year: expected %0d, got %0d", $time, want.year, got.year);
          end
        end
      end
      if (date_in.valid && date_in.ready) begin
        dates_due.push_back(add_days(date_in.start_day, date_in.start_month,
                                     date_in.start_year, date_in.days_to_add));
      end
      fails   <= fails + bad;
      pending <= 32'(dates_due.size());
    end
  end

  final begin
    if (dates_due.size() != 0) begin
      $display("%0t date_out: %0d expected words never arrived", $time, dates_due.size());
    end
  end

endmodule

// ===== tb/sv/tb_gregorian_date_add_days_unit.sv =====
module tb_gregorian_date_add_days_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  logic        clk;
  logic        rst;
  int unsigned fails;
  int unsigned pending;
  int unsigned sent_words;
  bit          steady;
  bit          long_hold_done;

  gda_in_if  date_in ();
  gda_out_if date_out ();

  gregorian_date_add_days_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .date_in  (date_in),
    .date_out (date_out)
  );

  gda_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .date_in  (date_in),
    .date_out (date_out),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 60);
  endfunction

  task automatic rest(input int unsigned gap);
    if (gap != 0) begin
      date_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_date(input day_t d, input month_t m, input year_t y, input add_t n);
    date_in.valid       <= 1'b1;
    date_in.start_day   <= d;
    date_in.start_month <= m;
    date_in.start_year  <= y;
    date_in.days_to_add <= n;
    @(posedge clk);
    while (!date_in.ready) @(posedge clk);
    sent_words++;
    rest(pick_gap());
  endtask

  task automatic drain();
    rest(1);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random();
    day_t        d;
    month_t      m;
    year_t       y;
    add_t        n;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      m = month_t'($urandom_range(MonthJan, MonthDec));
      d = day_t'(($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28));
      r = $urandom_range(0, 99);
      if (r < 15) begin
        y = year_t'(100 * $urandom_range(0, 163) + $urandom_range(0, 1) * 4);
      end else if (r < 85) begin
        y = year_t'($urandom_range(0, 9999));
      end else begin
        y = year_t'($urandom_range(0, 16383));
      end
    end else begin
      d = day_t'($urandom);
      m = month_t'($urandom);
      y = year_t'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = add_t'($urandom_range(0, 400));
    end else if (r < 90) begin
      n = add_t'($urandom_range(0, 4000));
    end else if (r < 98) begin
      n = add_t'($urandom_range(0, 32000));
    end else begin
      n = add_t'($urandom_range(0, 32767));
    end
    send_date(d, m, y, n);
  endtask

  initial begin : sink_side
    date_out.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!long_hold_done && sent_words >= 120) begin
        date_out.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        date_out.ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3))
          @(posedge clk);
      end else begin
        date_out.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : source_side
    rst                 <= 1'b1;
    date_in.valid       <= 1'b0;
    date_in.start_day   <= '0;
    date_in.start_month <= '0;
    date_in.start_year  <= '0;
    date_in.days_to_add <= '0;
    sent_words     = 0;
    steady         = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_date(day_t'(1),  MonthJan, year_t'(2024), add_t'(0));
    send_date(day_t'(31), MonthDec, year_t'(1999), add_t'(1));
    send_date(day_t'(28), MonthFeb, year_t'(2000), add_t'(1));
    send_date(day_t'(28), MonthFeb, year_t'(1900), add_t'(1));
    send_date(day_t'(28), MonthFeb, year_t'(2024), add_t'(1));
    send_date(day_t'(28), MonthFeb, year_t'(2023), add_t'(1));
    send_date(day_t'(0),  month_t'(5), year_t'(2010), add_t'(0));
    send_date(day_t'(15), month_t'(0), year_t'(2010), add_t'(10));
    send_date(day_t'(10), month_t'(13), year_t'(2010), add_t'(30));
    send_date(day_t'(10), month_t'(15), year_t'(2010), add_t'(0));
    send_date(day_t'(31), MonthFeb, year_t'(2021), add_t'(0));
    send_date(day_t'(31), month_t'(4), year_t'(2022), add_t'(0));
    send_date(day_t'(31), MonthFeb, year_t'(2000), add_t'(0));
    send_date(day_t'(31), MonthDec, year_t'(16383), add_t'(1));
    send_date(day_t'(1),  MonthJan, year_t'(16383), add_t'(32767));
    send_date(day_t'(31), month_t'(15), year_t'(16383), add_t'(32767));
    send_date(day_t'(0),  month_t'(0), year_t'(0), add_t'(0));
    send_date(day_t'(1),  MonthJan, year_t'(0), add_t'(366));
    send_date(day_t'(1),  month_t'(3), year_t'(9999), add_t'(32000));
    send_date(day_t'(31), MonthDec, year_t'(1600), add_t'(32767));
    send_date(day_t'(29), MonthFeb, year_t'(2100), add_t'(365));
    drain();

    for (int unsigned i = 0; i < 520; i++) begin
      steady = ((i / 40) % 4 == 3);
      if (i == 300) begin
        drain();
      end
      send_random();
    end
    steady = 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
